@@ sv/snp_pkg.sv @@
// ----------------------------------------------------------------------------
// snp_pkg
// Shared widths, register indexes and pipeline side-band types for the
// sphere nearest-point block.
// ----------------------------------------------------------------------------
package snp_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int RAD_W       = COORD_W - 1;
    localparam int SQR_W       = (2 * COORD_W - 1 > 63) ? 63 : 2 * COORD_W - 1;
    localparam int SUM_W       = 2 * COORD_W + 2;
    localparam int MAG_W       = COORD_W + 1;
    localparam int NUM_W       = COORD_W + RAD_W;
    localparam int QUO_W       = RAD_W;
    localparam int SQRT_STAGES = MAG_W;
    localparam int DIV_STAGES  = QUO_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = ((3 * COORD_W + SQR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X = 2'd0,
        CFG_CENTRE_Y = 2'd1,
        CFG_CENTRE_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0]              neg;
        logic [2:0][NUM_W-1:0]   num;
        logic [SQR_W-1:0]        srch;
    } t_mid_side;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0]              neg;
        logic                    mag_zero;
    } t_tail_side;

endpackage

@@ sv/snp_sqrt.sv @@
// ----------------------------------------------------------------------------
// snp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module snp_sqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [snp_pkg::SUM_W-1:0]  i_n,
    output logic [snp_pkg::MAG_W-1:0]  o_root
);
    import snp_pkg::*;

    localparam int TW = SUM_W + 2;

    logic [SUM_W-1:0] r_rem [SQRT_STAGES-1];
    logic [MAG_W-1:0] r_res [SQRT_STAGES];

    genvar j;
    generate
        for (j = 0; j < SQRT_STAGES; j++) begin : g_stage
            localparam int B = MAG_W - 1 - j;
            logic [SUM_W-1:0] w_rem_in;
            logic [MAG_W-1:0] w_res_in;
            logic [TW-1:0]    w_trial;
            logic             w_take;

            if (j == 0) begin : g_first
                assign w_rem_in = i_n;
                assign w_res_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[j-1];
                assign w_res_in = r_res[j-1];
            end

            assign w_trial = (TW'(w_res_in) << (B + 1)) | (TW'(1) << (2 * B));
            assign w_take  = w_trial <= TW'(w_rem_in);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_res[j] <= w_take ? (w_res_in | (MAG_W'(1) << B)) : w_res_in;
                end
            end

            if (j < SQRT_STAGES - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[j] <= w_take ? (w_rem_in - w_trial[SUM_W-1:0]) : w_rem_in;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQRT_STAGES-1];

endmodule

@@ sv/snp_div.sv @@
// ----------------------------------------------------------------------------
// snp_div
// Pipelined restoring divider, one quotient bit per stage, then a
// round-half-up stage.
// ----------------------------------------------------------------------------
module snp_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [snp_pkg::NUM_W-1:0]  i_num,
    input  logic [snp_pkg::MAG_W-1:0]  i_den,
    output logic [snp_pkg::QUO_W-1:0]  o_quo
);
    import snp_pkg::*;

    logic [MAG_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [MAG_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];
    logic [QUO_W-1:0] r_qf;

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic [MAG_W-1:0] w_rem_in;
            logic [QUO_W-1:0] w_low_in;
            logic [MAG_W-1:0] w_den_in;
            logic [QUO_W-1:0] w_q_in;
            logic [MAG_W:0]   w_t;
            logic [MAG_W:0]   w_diff;
            logic             w_take;

            if (k == 0) begin : g_first
                assign w_rem_in = MAG_W'(i_num[NUM_W-1:QUO_W]);
                assign w_low_in = i_num[QUO_W-1:0];
                assign w_den_in = i_den;
                assign w_q_in   = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_low_in = r_low[k-1];
                assign w_den_in = r_den[k-1];
                assign w_q_in   = r_q[k-1];
            end

            assign w_t    = {w_rem_in, w_low_in[QUO_W-1]};
            assign w_diff = w_t - {1'b0, w_den_in};
            assign w_take = w_t >= {1'b0, w_den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_take ? w_diff[MAG_W-1:0] : w_t[MAG_W-1:0];
                    r_low[k] <= w_low_in << 1;
                    r_den[k] <= w_den_in;
                    r_q[k]   <= {w_q_in[QUO_W-2:0], w_take};
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qf <= r_q[QUO_W-1]
                  + QUO_W'({r_rem[QUO_W-1], 1'b0} >= {1'b0, r_den[QUO_W-1]});
        end
    end

    assign o_quo = r_qf;

endmodule

@@ sv/sphere_nearest_point.sv @@
// ----------------------------------------------------------------------------
// sphere_nearest_point
// Nearest point on a configured sphere to a stream of 3-D sample points.
// Pipeline from input transfer to result valid: 3 front stages, 33-stage
// square root, 32-stage divider, output register.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on m_axis_tready. Reset clears all valid bits, centre to (0,0,0)
// and radius to 1.0.
// ----------------------------------------------------------------------------
module sphere_nearest_point (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [snp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [snp_pkg::COORD_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_x, sample_y, sample_z, search_dist_sqr, zero pad
    input  logic [snp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // point_x, point_y, point_z
    output logic [snp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // hit
    output logic                              m_axis_tuser
);
    import snp_pkg::*;

    localparam int PIPE_D  = 3 + SQRT_STAGES + DIV_STAGES + 1;
    localparam int HIT_DLY = DIV_STAGES - 3;

    logic               w_en;
    logic [PIPE_D-1:0]  r_vld;

    logic signed [COORD_W-1:0] r_c [3];
    logic [RAD_W-1:0]          r_rad;

    // front stages
    logic [COORD_W-1:0]   r1_s [3];
    logic [COORD_W:0]     r1_d [3];
    logic [SQR_W-1:0]     r1_srch;
    logic [2*COORD_W-1:0] r2_sq [3];
    logic [NUM_W-1:0]     r2_num [3];
    logic [2:0]           r2_neg;
    logic [COORD_W-1:0]   r2_s [3];
    logic [SQR_W-1:0]     r2_srch;
    logic [SUM_W-1:0]     r3_sum;
    t_mid_side            r3_side;
    t_mid_side            r_mid [SQRT_STAGES];

    logic [MAG_W-1:0]     w_mag;
    logic [QUO_W-1:0]     w_quo [3];

    logic [MAG_W-1:0]     r_gap;
    logic [SQR_W-1:0]     r_srch_a;
    logic [2*MAG_W-1:0]   r_gsq;
    logic [SQR_W-1:0]     r_srch_b;
    logic                 r_hit [HIT_DLY+1];
    t_tail_side           r_tail [DIV_STAGES];

    logic                 r_out_hit;
    logic [COORD_W-1:0]   r_out_p [3];
    logic [COORD_W-1:0]   n_out_p [3];
    logic [SQR_W-1:0]     w_sq_sat;
    logic [MAG_W-1:0]     w_rad_ext;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[PIPE_D-1];
    assign w_rad_ext     = MAG_W'(r_rad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_D-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
            r_c[1] <= '0;
            r_c[2] <= '0;
            r_rad  <= RAD_W'(1) << FRAC_W;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTRE_X: r_c[0] <= i_cfg_wdata;
                CFG_CENTRE_Y: r_c[1] <= i_cfg_wdata;
                CFG_CENTRE_Z: r_c[2] <= i_cfg_wdata;
                CFG_RADIUS:   r_rad  <= i_cfg_wdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // offset, squares, products, sum
    always_ff @(posedge i_clk) begin
        logic [COORD_W-1:0] v_s;
        logic [COORD_W:0]   v_abs;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                v_s     = s_axis_tdata[i*COORD_W +: COORD_W];
                r1_s[i] <= v_s;
                r1_d[i] <= {v_s[COORD_W-1], v_s} - {r_c[i][COORD_W-1], r_c[i]};

                v_abs      = r1_d[i][COORD_W] ? -r1_d[i] : r1_d[i];
                r2_sq[i]  <= (2*COORD_W)'(v_abs[COORD_W-1:0])
                           * (2*COORD_W)'(v_abs[COORD_W-1:0]);
                r2_num[i] <= NUM_W'(v_abs[COORD_W-1:0]) * NUM_W'(r_rad);
                r2_neg[i] <= r1_d[i][COORD_W];
                r2_s[i]   <= r1_s[i];

                r3_side.s[i]   <= r2_s[i];
                r3_side.num[i] <= r2_num[i];
            end
            r1_srch        <= s_axis_tdata[3*COORD_W +: SQR_W];
            r2_srch        <= r1_srch;
            r3_sum         <= SUM_W'(r2_sq[0]) + SUM_W'(r2_sq[1]) + SUM_W'(r2_sq[2]);
            r3_side.neg    <= r2_neg;
            r3_side.srch   <= r2_srch;
        end
    end

    snp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (r3_sum),
        .o_root (w_mag)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= r3_side;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                r_mid[j] <= r_mid[j-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            snp_div u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r_mid[SQRT_STAGES-1].num[g]),
                .i_den (w_mag),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    // surface distance test
    assign w_sq_sat = (r_gsq > (2*MAG_W)'({SQR_W{1'b1}})) ? {SQR_W{1'b1}}
                                                            : r_gsq[SQR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gap    <= (w_mag > w_rad_ext) ? (w_mag - w_rad_ext) : (w_rad_ext - w_mag);
            r_srch_a <= r_mid[SQRT_STAGES-1].srch;
            r_gsq    <= (2*MAG_W)'(r_gap) * (2*MAG_W)'(r_gap);
            r_srch_b <= r_srch_a;
            r_hit[0] <= r_srch_b > w_sq_sat;
            for (int j = 1; j <= HIT_DLY; j++) begin
                r_hit[j] <= r_hit[j-1];
            end

            r_tail[0].s        <= r_mid[SQRT_STAGES-1].s;
            r_tail[0].neg      <= r_mid[SQRT_STAGES-1].neg;
            r_tail[0].mag_zero <= w_mag == '0;
            for (int j = 1; j < DIV_STAGES; j++) begin
                r_tail[j] <= r_tail[j-1];
            end
        end
    end

    // projection, saturation and selection
    always_comb begin
        logic [COORD_W+1:0] v_off;
        logic [COORD_W+1:0] v_sum;
        for (int i = 0; i < 3; i++) begin
            v_off = (COORD_W+2)'(w_quo[i]);
            if (r_tail[DIV_STAGES-1].mag_zero) begin
                v_off = (i == 0) ? (COORD_W+2)'(r_rad) : '0;
            end else if (r_tail[DIV_STAGES-1].neg[i]) begin
                v_off = -v_off;
            end
            v_sum = {{2{r_c[i][COORD_W-1]}}, r_c[i]} + v_off;
            if (v_sum[COORD_W+1:COORD_W-1] != 3'b000
                    && v_sum[COORD_W+1:COORD_W-1] != 3'b111) begin
                n_out_p[i] = v_sum[COORD_W+1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                              : {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                n_out_p[i] = v_sum[COORD_W-1:0];
            end
            if (!r_hit[HIT_DLY]) begin
                n_out_p[i] = r_tail[DIV_STAGES-1].s[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= r_hit[HIT_DLY];
            for (int i = 0; i < 3; i++) begin
                r_out_p[i] <= n_out_p[i];
            end
        end
    end

    assign m_axis_tuser = r_out_hit;
    assign m_axis_tdata = OUT_TDATA_W'({r_out_p[2], r_out_p[1], r_out_p[0]});

endmodule

@@ sv/snp_checker.sv @@
// ----------------------------------------------------------------------------
// snp_checker
// Port-level checks for the sphere nearest-point pipeline.
// ----------------------------------------------------------------------------
module snp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [snp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser
);
    import snp_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output slot");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown({m_axis_tuser, m_axis_tdata}))
        else $error("result transfer carries unknown bits");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind sphere_nearest_point snp_checker u_snp_checker (.*);

@@ sim/sphere_nearest_point_tb.sv @@
// ----------------------------------------------------------------------------
// sphere_nearest_point_tb
// Self-checking bench for the sphere nearest-point block. A queue-fed driver
// streams sample points, and each accepted transfer is predicted bit for bit.
// A monitor compares every result transfer with the oldest prediction. The
// run steps through several sphere settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module sphere_nearest_point_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import snp_pkg::*;

    localparam int LATENCY   = 69;
    localparam int WDOG_MAX  = 5000;
    localparam logic [62:0] SRCH_MAX = {63{1'b1}};

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [62:0]        srch;
    } t_sample;

    typedef struct {
        logic        hit;
        logic [31:0] px, py, pz;
    } t_surf_pt;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [COORD_W-1:0]     i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    sphere_nearest_point u_top (.*);

    t_sample  pending_q[$];
    t_surf_pt expected_q[$];
    logic signed [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0]        radius;
    int  src_idle_pct, snk_stall_pct;
    int  errors;
    int  idle_cycles;
    logic took;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_surf_pt nearest_point(t_sample s);
        longint      sv[3], cv[3], dv[3];
        logic [63:0] av[3];
        logic [127:0] sum, gsq, num;
        logic [63:0] mag, cand, gap, q;
        logic [62:0] sq;
        longint      off;
        logic [31:0] pt[3];
        t_surf_pt    r;
        sv[0] = s.x; sv[1] = s.y; sv[2] = s.z;
        cv[0] = ctr_x; cv[1] = ctr_y; cv[2] = ctr_z;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            dv[i] = sv[i] - cv[i];
            av[i] = (dv[i] < 0) ? -dv[i] : dv[i];
            sum += 128'(av[i]) * 128'(av[i]);
        end
        mag = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = mag | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= sum) mag = cand;
        end
        gap = (mag > 64'(radius)) ? mag - 64'(radius) : 64'(radius) - mag;
        gsq = 128'(gap) * 128'(gap);
        sq  = (gsq > 128'(SRCH_MAX)) ? SRCH_MAX : gsq[62:0];
        r.hit = s.srch > sq;
        if (!r.hit) begin
            for (int i = 0; i < 3; i++) pt[i] = clamp_coord(sv[i]);
        end else if (mag == 0) begin
            pt[0] = clamp_coord(cv[0] + longint'(radius));
            pt[1] = clamp_coord(cv[1]);
            pt[2] = clamp_coord(cv[2]);
        end else begin
            for (int i = 0; i < 3; i++) begin
                num = 128'(av[i]) * 128'(radius);
                q   = 64'((2 * num + 128'(mag)) / (2 * 128'(mag)));
                off = (dv[i] < 0) ? -longint'(q) : longint'(q);
                pt[i] = clamp_coord(cv[i] + off);
            end
        end
        r.px = pt[0]; r.py = pt[1]; r.pz = pt[2];
        return r;
    endfunction

    // driver: presents the queue head, pops it on transfer
    always @(posedge i_clk) begin
        took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            expected_q.push_back(nearest_point(pending_q[0]));
            void'(pending_q.pop_front());
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        if (!s_axis_tvalid || took) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_q[0].srch, pending_q[0].z,
                                  pending_q[0].y, pending_q[0].x};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_surf_pt exp_pt;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result hit=%b data=%h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                exp_pt = expected_q.pop_front();
                if (m_axis_tuser !== exp_pt.hit || m_axis_tdata[31:0] !== exp_pt.px ||
                    m_axis_tdata[63:32] !== exp_pt.py ||
                    m_axis_tdata[95:64] !== exp_pt.pz) begin
                    $display("%0t: mismatch exp hit=%b pt=%h,%h,%h got hit=%b pt=%h,%h,%h",
                             $time, exp_pt.hit, exp_pt.px, exp_pt.py, exp_pt.pz,
                             m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                             m_axis_tdata[95:64]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_CENTRE_X: ctr_x  = val;
            CFG_CENTRE_Y: ctr_y  = val;
            CFG_CENTRE_Z: ctr_z  = val;
            CFG_RADIUS:   radius = val[30:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [30:0] rad);
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_CENTRE_Z, cz);
        write_reg(CFG_RADIUS, {1'b0, rad});
    endtask

    task automatic add_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [62:0] srch);
        t_sample s;
        s.x = x; s.y = y; s.z = z; s.srch = srch;
        pending_q.push_back(s);
    endtask

    function automatic logic [31:0] near_coord(logic signed [31:0] c, int span);
        longint v;
        v = longint'(c) + longint'($urandom_range(2 * span)) - span;
        return clamp_coord(v);
    endfunction

    task automatic add_random(int n);
        logic [31:0] x, y, z;
        logic [62:0] srch;
        int span;
        for (int k = 0; k < n; k++) begin
            span = (radius > 31'd1000) ? 2 * int'(radius > 31'h3fffffff ?
                   31'h3fffffff : radius) : 300000;
            if ($urandom_range(3) == 0) begin
                x = $urandom; y = $urandom; z = $urandom;
            end else begin
                x = near_coord(ctr_x, span);
                y = near_coord(ctr_y, span);
                z = near_coord(ctr_z, span);
            end
            case ($urandom_range(5))
                0:       srch = 63'({$urandom, $urandom} >> 1);
                1:       srch = 63'($urandom) << $urandom_range(31);
                2:       srch = SRCH_MAX;
                3:       srch = '0;
                default: srch = 63'({$urandom, $urandom} >> $urandom_range(1, 40));
            endcase
            add_sample(x, y, z, srch);
        end
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        errors = 0; idle_cycles = 0; took = 1'b0;
        src_idle_pct = 0; snk_stall_pct = 0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0; radius = 31'd65536;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset sphere
        add_sample(0, 0, 0, SRCH_MAX);
        add_sample(0, 0, 0, '0);
        add_sample(32'h00010000, 0, 0, 63'd1);
        add_sample(0, 32'hfffe0000, 0, 63'h1_0000_0000);
        add_sample(0, 32'hfffe0000, 0, 63'h1_0000_0001);
        add_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, SRCH_MAX);
        add_sample(32'h80000000, 32'h80000000, 32'h80000000, SRCH_MAX);
        add_sample(32'h80000000, 32'h7fffffff, 0, 63'({$urandom, $urandom} >> 1));
        add_sample(3, 4, 0, SRCH_MAX);
        add_sample(32'hfffffffd, 32'hfffffffc, 0, SRCH_MAX);
        add_sample(32'h00008000, 32'hffff8000, 32'h00008000, 63'h1_0000_0000);
        add_sample(32'h00020000, 32'h00020000, 32'hfffe0000, SRCH_MAX);
        add_sample(1, 0, 0, 63'h1_0000_0000);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_sphere(0, 0, 0, 31'd65536);
                1: set_sphere(0, 0, 0, 31'h7fffffff);
                2: set_sphere(32'h7fffffff, 32'h80000000, 0, 31'd0);
                3: set_sphere(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
                4: set_sphere($urandom, $urandom, $urandom, 31'($urandom_range(1 << 22)));
                5: set_sphere($urandom >> 4, -($urandom >> 4), $urandom,
                              31'($urandom));
                default: ;
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
                3: begin src_idle_pct = 32; snk_stall_pct = 32; end
                default: ;
            endcase
            if (ph == 2) begin
                add_sample(32'h7fffffff, 32'h80000000, 0, SRCH_MAX);
                add_sample(32'h7fff0000, 32'h80010000, 0, SRCH_MAX);
            end
            add_random(255);
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
